// ----- sv/rtk_pkg.sv -----
`default_nettype none

package rtk_pkg;

  // Request codes
  typedef enum logic [2:0] {
    REQ_ADD         = 3'd0,
    REQ_REMOVE      = 3'd1,
    REQ_FIND_FIRST  = 3'd2,
    REQ_FIND_LAST   = 3'd3,
    REQ_FIND_NUMBER = 3'd4,
    REQ_LIST        = 3'd5
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RECORD    = 2'd3
  } status_e;

  localparam int unsigned NameBytes = 19;

  typedef struct packed {
    logic [23:0] c;
    logic [63:0] b;
    logic [63:0] a;
  } name_t;

  typedef struct packed {
    logic signed [31:0] number;
    name_t              first;
    name_t              last;
  } rec_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Force every byte after the first zero byte to zero
  function automatic name_t clean_name(input name_t n);
    logic [8*NameBytes-1:0] v;
    logic                   ended;
    v     = n;
    ended = 1'b0;
    for (int i = 0; i < NameBytes; i++) begin
      if (ended) begin
        v[8*i +: 8] = 8'h00;
      end else if (v[8*i +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return name_t'(v);
  endfunction

endpackage

`default_nettype wire

// ----- sv/rtk_cell.sv -----
`default_nettype none

// One table slot: takes its neighbour's record on a shift, or a broadcast
// record on a load (load wins).
module rtk_cell (
  input  wire logic               clk_i,
  input  wire rtk_pkg::cell_ctrl_t ctrl_i,
  input  wire rtk_pkg::rec_t      nbr_i,
  input  wire rtk_pkg::rec_t      load_i,
  output rtk_pkg::rec_t           rec_o
);

  rtk_pkg::rec_t rec_q;
  rtk_pkg::rec_t rec_d;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.load) begin
      rec_d = load_i;
    end else if (ctrl_i.shift) begin
      rec_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

// ----- sv/record_table_key_search.sv -----
`default_nettype none

// Channel | Handshake                 | Payload
// --------+---------------------------+-------------------------------------------
// in      | in_valid_i / in_ready_o   | req_type, key_number, first/last name a,b,c
// out     | out_valid_o / out_ready_i | status, out_number, out_first/last a,b,c, is_last
//
// Add and unknown requests skip the scan: accept, then result.
// Remove, find and list rotate the cell chain once: TABLE_DEPTH scan steps,
// one per cycle while the output slot is free, then the end item.
// A stalled output register holds the scan step until the slot frees.
// Reset empties the table (fill count zero); cell contents are not cleared.
// A new request is taken once the previous end item sits in the output register.
module record_table_key_search #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         req_type_i,
  input  wire logic signed [31:0] key_number_i,
  input  wire logic [63:0]        first_name_a_i,
  input  wire logic [63:0]        first_name_b_i,
  input  wire logic [23:0]        first_name_c_i,
  input  wire logic [63:0]        last_name_a_i,
  input  wire logic [63:0]        last_name_b_i,
  input  wire logic [23:0]        last_name_c_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [31:0]      out_number_o,
  output logic [63:0]             out_first_a_o,
  output logic [63:0]             out_first_b_o,
  output logic [23:0]             out_first_c_o,
  output logic [63:0]             out_last_a_o,
  output logic [63:0]             out_last_b_o,
  output logic [23:0]             out_last_c_o,
  output logic                    is_last_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e                state_q, state_d;
  logic [IW-1:0]         step_q, step_d;
  logic [IW-1:0]         wr_q, wr_d;
  logic [CW-1:0]         kept_q, kept_d;
  logic [CW-1:0]         fill_q, fill_d;
  rtk_pkg::req_e         req_q, req_d;
  rtk_pkg::rec_t         key_q, key_d;
  logic                  out_valid_q, out_valid_d;
  rtk_pkg::status_e      out_status_q, out_status_d;
  rtk_pkg::rec_t         out_rec_q, out_rec_d;
  logic                  out_last_q, out_last_d;

  rtk_pkg::rec_t         cell_rec [TABLE_DEPTH];
  rtk_pkg::cell_ctrl_t   cell_ctrl [TABLE_DEPTH];
  rtk_pkg::rec_t         load_rec;
  rtk_pkg::rec_t         head;

  logic                  out_free;
  logic                  scan_step;
  logic                  in_range;
  logic                  hit;
  logic                  drop;
  logic                  emit_rec;
  logic                  add_wr;
  logic                  full;
  logic [IW-1:0]         push_pos;
  logic [IW-1:0]         fill_idx;

  assign out_free  = !out_valid_q || out_ready_i;
  assign head      = cell_rec[0];
  assign in_range  = CW'(step_q) < fill_q;
  assign scan_step = (state_q == S_SCAN) && out_free;
  assign full      = fill_q >= CW'(TABLE_DEPTH);
  assign add_wr    = (state_q == S_FIN) && out_free && (req_q == rtk_pkg::REQ_ADD) && !full;
  assign fill_idx  = fill_q[IW-1:0];

  // Match of the head record against the request key
  always_comb begin
    case (req_q)
      rtk_pkg::REQ_FIND_FIRST:  hit = (head.first == key_q.first);
      rtk_pkg::REQ_FIND_LAST:   hit = (head.last == key_q.last);
      rtk_pkg::REQ_FIND_NUMBER: hit = (head.number == key_q.number);
      rtk_pkg::REQ_LIST:        hit = 1'b1;
      default:                  hit = 1'b0;
    endcase
  end

  assign drop     = (req_q == rtk_pkg::REQ_REMOVE) && in_range &&
                    (head.number == key_q.number);
  assign emit_rec = in_range && hit;

  // A kept head lands where it ends up at slot wr after the remaining shifts
  assign push_pos = IW'({1'b0, wr_q} + (IW + 1)'(TABLE_DEPTH - 1) - {1'b0, step_q});
  assign load_rec = (state_q == S_FIN) ? key_q : head;

  // Cell chain, each cell fed by its upper neighbour, the top one wraps round
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    assign cell_ctrl[j].shift = scan_step;
    assign cell_ctrl[j].load  = (scan_step && !drop && (push_pos == IW'(j))) ||
                                (add_wr && (fill_idx == IW'(j)));
    rtk_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[j]),
      .nbr_i  (cell_rec[(j + 1) % TABLE_DEPTH]),
      .load_i (load_rec),
      .rec_o  (cell_rec[j])
    );
  end

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    wr_d         = wr_q;
    kept_d       = kept_q;
    fill_d       = fill_q;
    req_d        = req_q;
    key_d        = key_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_rec_d    = out_rec_q;
    out_last_d   = out_last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = rtk_pkg::req_e'(req_type_i);
          key_d.number = key_number_i;
          key_d.first  = rtk_pkg::clean_name({first_name_c_i, first_name_b_i,
                                              first_name_a_i});
          key_d.last   = rtk_pkg::clean_name({last_name_c_i, last_name_b_i,
                                              last_name_a_i});
          step_d       = '0;
          wr_d         = '0;
          kept_d       = '0;
          case (rtk_pkg::req_e'(req_type_i)) inside
            rtk_pkg::REQ_REMOVE, rtk_pkg::REQ_FIND_FIRST, rtk_pkg::REQ_FIND_LAST,
            rtk_pkg::REQ_FIND_NUMBER, rtk_pkg::REQ_LIST: state_d = S_SCAN;
            default:                                     state_d = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (emit_rec) begin
            out_valid_d  = 1'b1;
            out_status_d = rtk_pkg::ST_RECORD;
            out_rec_d    = head;
            out_last_d   = 1'b0;
          end
          if (!drop) begin
            wr_d = wr_q + IW'(1);
          end
          if (in_range && !drop) begin
            kept_d = kept_q + CW'(1);
          end
          step_d = step_q + IW'(1);
          if (step_q == IW'(TABLE_DEPTH - 1)) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_rec_d    = '0;
          out_last_d   = 1'b1;
          out_status_d = rtk_pkg::ST_OK;
          case (req_q)
            rtk_pkg::REQ_ADD: begin
              if (full) begin
                out_status_d = rtk_pkg::ST_FULL;
              end else begin
                fill_d = fill_q + CW'(1);
              end
            end
            rtk_pkg::REQ_REMOVE: begin
              fill_d = kept_q;
              if (kept_q == fill_q) begin
                out_status_d = rtk_pkg::ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      wr_q         <= '0;
      kept_q       <= '0;
      fill_q       <= '0;
      req_q        <= rtk_pkg::REQ_ADD;
      key_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= rtk_pkg::ST_OK;
      out_rec_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      wr_q         <= wr_d;
      kept_q       <= kept_d;
      fill_q       <= fill_d;
      req_q        <= req_d;
      key_q        <= key_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_rec_q    <= out_rec_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_number_o  = out_rec_q.number;
  assign out_first_a_o = out_rec_q.first.a;
  assign out_first_b_o = out_rec_q.first.b;
  assign out_first_c_o = out_rec_q.first.c;
  assign out_last_a_o  = out_rec_q.last.a;
  assign out_last_b_o  = out_rec_q.last.b;
  assign out_last_c_o  = out_rec_q.last.c;
  assign is_last_o     = out_last_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken while one is in progress");

  a_idle_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(fill_q))
    else $error("fill count moved while idle");

  a_scan_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !out_free) |=> $stable(step_q))
    else $error("scan advanced while output slot busy");

endmodule

`default_nettype wire

// ----- verif/record_table_key_search_test.sv -----
`default_nettype none

module record_table_key_search_test;
  import rtk_pkg::*;

  localparam int unsigned ROWS = 16;
  localparam int unsigned NAME_LEN = 19;
  // Request codes the block does not define; it answers them with a bare ok
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef struct {
    status_e            status;
    logic signed [31:0] number;
    name_t              first;
    name_t              last;
    logic               end_flag;
  } reply_t;

  // Mirror of the record table: predicts the replies of each request and
  // holds them until the block delivers them
  class directory_mirror;
    int unsigned        occupancy;
    logic signed [31:0] num_col[ROWS];
    name_t              first_col[ROWS];
    name_t              last_col[ROWS];
    reply_t             awaited[$];
    int unsigned        errors;
    int unsigned        replies_seen;
    int unsigned        refused_full;
    int unsigned        records_sent;
    int unsigned        req_count[8];

    // A name ends at its first zero byte; everything above it is dropped
    function name_t trim_at_nul(name_t raw);
      int    stop;
      name_t keep;
      stop = NAME_LEN;
      for (int idx = NAME_LEN - 1; idx >= 0; idx--) begin
        if (raw[8*idx +: 8] == 8'h00) stop = idx;
      end
      keep = '1;
      if (stop < NAME_LEN) keep = (name_t'(1) << (8 * stop)) - name_t'(1);
      return raw & keep;
    endfunction

    function void expect_reply(status_e st, int idx, logic fin);
      reply_t r;
      r.status   = st;
      r.number   = '0;
      r.first    = '0;
      r.last     = '0;
      r.end_flag = fin;
      if (idx >= 0) begin
        r.number = num_col[idx];
        r.first  = first_col[idx];
        r.last   = last_col[idx];
        records_sent++;
      end
      awaited.push_back(r);
    endfunction

    function void apply_request(logic [2:0] req, logic signed [31:0] key,
                                name_t fn_raw, name_t ln_raw);
      name_t       fn;
      name_t       ln;
      int unsigned kept;
      bit          hit;
      fn = trim_at_nul(fn_raw);
      ln = trim_at_nul(ln_raw);
      req_count[req]++;
      case (req)
        REQ_ADD: begin
          if (occupancy >= ROWS) begin
            refused_full++;
            expect_reply(ST_FULL, -1, 1'b1);
          end else begin
            num_col[occupancy]   = key;
            first_col[occupancy] = fn;
            last_col[occupancy]  = ln;
            occupancy++;
            expect_reply(ST_OK, -1, 1'b1);
          end
        end
        REQ_REMOVE: begin
          // compact in place, order kept, every match dropped
          kept = 0;
          for (int i = 0; i < occupancy; i++) begin
            if (num_col[i] != key) begin
              num_col[kept]   = num_col[i];
              first_col[kept] = first_col[i];
              last_col[kept]  = last_col[i];
              kept++;
            end
          end
          expect_reply((kept != occupancy) ? ST_OK : ST_NOT_FOUND, -1, 1'b1);
          occupancy = kept;
        end
        REQ_FIND_FIRST, REQ_FIND_LAST, REQ_FIND_NUMBER, REQ_LIST: begin
          for (int i = 0; i < occupancy; i++) begin
            case (req)
              REQ_FIND_FIRST:  hit = (first_col[i] == fn);
              REQ_FIND_LAST:   hit = (last_col[i] == ln);
              REQ_FIND_NUMBER: hit = (num_col[i] == key);
              default:         hit = 1'b1;
            endcase
            if (hit) expect_reply(ST_RECORD, i, 1'b0);
          end
          expect_reply(ST_OK, -1, 1'b1);
        end
        default: expect_reply(ST_OK, -1, 1'b1);
      endcase
    endfunction

    function void match_reply(reply_t got);
      reply_t      want;
      logic [63:0] w_v[9];
      logic [63:0] g_v[9];
      string       tag[9];
      replies_seen++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: status %0d number %h last %b",
                 $time, got.status, got.number, got.end_flag);
        return;
      end
      want = awaited.pop_front();
      tag = '{"status", "out_number", "out_first_a", "out_first_b", "out_first_c",
              "out_last_a", "out_last_b", "out_last_c", "is_last"};
      w_v = '{64'(want.status), 64'(unsigned'(want.number)), want.first.a,
              want.first.b, 64'(want.first.c), want.last.a, want.last.b,
              64'(want.last.c), 64'(want.end_flag)};
      g_v = '{64'(got.status), 64'(unsigned'(got.number)), got.first.a,
              got.first.b, 64'(got.first.c), got.last.a, got.last.b,
              64'(got.last.c), 64'(got.end_flag)};
      for (int k = 0; k < 9; k++) begin
        if (w_v[k] !== g_v[k]) begin
          errors++;
          $display("%0t: %s expected %h got %h", $time, tag[k], w_v[k], g_v[k]);
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic [2:0]         req_type_i = REQ_ADD;
  logic signed [31:0] key_number_i = '0;
  logic [63:0]        first_name_a_i = '0;
  logic [63:0]        first_name_b_i = '0;
  logic [23:0]        first_name_c_i = '0;
  logic [63:0]        last_name_a_i = '0;
  logic [63:0]        last_name_b_i = '0;
  logic [23:0]        last_name_c_i = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] out_number_o;
  logic [63:0]        out_first_a_o;
  logic [63:0]        out_first_b_o;
  logic [23:0]        out_first_c_o;
  logic [63:0]        out_last_a_o;
  logic [63:0]        out_last_b_o;
  logic [23:0]        out_last_c_o;
  logic               is_last_o;

  directory_mirror    mirror = new;
  int unsigned        send_idle_pct = 17;
  int unsigned        recv_idle_pct = 78;
  name_t              base_names[8];
  int unsigned        base_len[8];
  logic signed [31:0] number_pool[6];

  record_table_key_search #(.TABLE_DEPTH(ROWS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .key_number_i   (key_number_i),
    .first_name_a_i (first_name_a_i),
    .first_name_b_i (first_name_b_i),
    .first_name_c_i (first_name_c_i),
    .last_name_a_i  (last_name_a_i),
    .last_name_b_i  (last_name_b_i),
    .last_name_c_i  (last_name_c_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_number_o   (out_number_o),
    .out_first_a_o  (out_first_a_o),
    .out_first_b_o  (out_first_b_o),
    .out_first_c_o  (out_first_c_o),
    .out_last_a_o   (out_last_a_o),
    .out_last_b_o   (out_last_b_o),
    .out_last_c_o   (out_last_c_o),
    .is_last_o      (is_last_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  // Result side: check each transaction, then pick the next ready at random
  initial begin
    reply_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.status   = status_e'(status_o);
        got.number   = out_number_o;
        got.first    = '{c: out_first_c_o, b: out_first_b_o, a: out_first_a_o};
        got.last     = '{c: out_last_c_o, b: out_last_b_o, a: out_last_a_o};
        got.end_flag = is_last_o;
        mirror.match_reply(got);
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One request transaction; returns at the edge that accepted it
  task automatic send_request(input logic [2:0] req, input logic signed [31:0] key,
                              input name_t fn, input name_t ln);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    key_number_i   <= key;
    first_name_a_i <= fn.a;
    first_name_b_i <= fn.b;
    first_name_c_i <= fn.c;
    last_name_a_i  <= ln.a;
    last_name_b_i  <= ln.b;
    last_name_c_i  <= ln.c;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.apply_request(req, key, fn, ln);
  endtask

  // Hold off new requests until every outstanding result has arrived
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.awaited.size() != 0);
  endtask

  // Mostly names from a small pool, so finds hit; junk above the terminator
  function automatic name_t make_name();
    name_t       n;
    int unsigned k;
    if ($urandom_range(99) < 25) begin
      n.a = {$urandom, $urandom};
      n.b = {$urandom, $urandom};
      n.c = 24'($urandom);
      return n;
    end
    k = $urandom_range(7);
    n = base_names[k];
    for (int idx = base_len[k] + 1; idx < NAME_LEN; idx++) begin
      n[8*idx +: 8] = 8'($urandom);
    end
    return n;
  endfunction

  function automatic logic signed [31:0] pick_number();
    if ($urandom_range(99) < 65) return number_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  task automatic random_request(input bit filling);
    int unsigned        roll;
    logic [2:0]         req;
    logic signed [31:0] key;
    name_t              fn;
    name_t              ln;
    roll = $urandom_range(99);
    if (roll < (filling ? 65 : 15)) req = REQ_ADD;
    else if (roll < (filling ? 72 : 45)) req = REQ_REMOVE;
    else if (roll < (filling ? 78 : 57)) req = REQ_FIND_FIRST;
    else if (roll < (filling ? 84 : 69)) req = REQ_FIND_LAST;
    else if (roll < (filling ? 90 : 81)) req = REQ_FIND_NUMBER;
    else if (roll < (filling ? 97 : 95)) req = REQ_LIST;
    else req = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    key = pick_number();
    fn  = make_name();
    ln  = make_name();
    send_request(req, key, fn, ln);
  endtask

  task automatic random_phase(input int unsigned count);
    bit filling;
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      // alternate between filling the table and thinning it out
      if (n % 30 == 0 && n != 0) filling = !filling;
      random_request(filling);
    end
    wait_idle();
  endtask

  // Stimulus
  initial begin
    name_t full_ones;
    name_t empty_junk;
    name_t empty_other;
    name_t mid_junk;
    name_t mid_other;
    int    lens[8];

    full_ones   = '1;
    empty_junk  = {{18{8'hFF}}, 8'h00};
    empty_other = {{18{8'h77}}, 8'h00};
    mid_junk    = {{13{8'hA5}}, 8'h00, 40'h4a_4f_48_4e_53};
    mid_other   = {{13{8'h3C}}, 8'h00, 40'h4a_4f_48_4e_53};

    lens = '{0, 1, 8, 16, 18, 19, $urandom_range(19), $urandom_range(19)};
    for (int k = 0; k < 8; k++) begin
      base_len[k]   = lens[k];
      base_names[k] = '0;
      for (int idx = 0; idx < lens[k]; idx++) begin
        base_names[k][8*idx +: 8] = 8'($urandom_range(255, 1));
      end
    end
    number_pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, $urandom, $urandom};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, name terminators, duplicates
    send_request(REQ_LIST, 0, '0, '0);
    send_request(REQ_FIND_NUMBER, 0, full_ones, full_ones);
    send_request(REQ_REMOVE, 0, '0, '0);
    send_request(REQ_ADD, 32'sh8000_0000, full_ones, empty_junk);
    send_request(REQ_ADD, 32'sh7FFF_FFFF, mid_junk, full_ones);
    send_request(REQ_ADD, 0, full_ones, empty_other);
    send_request(REQ_ADD, 0, mid_other, mid_junk);
    send_request(REQ_ADD, -1, '0, '0);
    send_request(REQ_SPARE_LO, 0, '0, '0);
    send_request(REQ_SPARE_HI, -1, full_ones, full_ones);
    send_request(REQ_FIND_FIRST, 0, mid_other, '0);
    send_request(REQ_FIND_FIRST, 0, full_ones, '0);
    send_request(REQ_FIND_LAST, 0, '0, empty_other);
    send_request(REQ_FIND_LAST, 0, '0, full_ones);
    send_request(REQ_FIND_NUMBER, 0, '0, '0);
    send_request(REQ_LIST, 0, '0, '0);
    send_request(REQ_REMOVE, 0, '0, '0);
    send_request(REQ_FIND_NUMBER, 0, '0, '0);
    send_request(REQ_REMOVE, 0, '0, '0);
    send_request(REQ_REMOVE, 32'sh8000_0000, '0, '0);
    send_request(REQ_LIST, 0, '0, '0);
    wait_idle();

    // Random: sender idles lightly, receiver heavily; then swapped; then none
    random_phase(120);
    send_idle_pct = 78;
    recv_idle_pct = 17;
    random_phase(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(110);

    repeat (ROWS + 4) @(posedge clk_i);
    $display("requests: %0d add, %0d remove, %0d find first, %0d find last, %0d find number",
             mirror.req_count[REQ_ADD], mirror.req_count[REQ_REMOVE],
             mirror.req_count[REQ_FIND_FIRST], mirror.req_count[REQ_FIND_LAST],
             mirror.req_count[REQ_FIND_NUMBER]);
    $display("%0d lists, %0d unknown; %0d results checked, %0d records, %0d adds refused",
             mirror.req_count[REQ_LIST],
             mirror.req_count[REQ_SPARE_LO] + mirror.req_count[REQ_SPARE_HI],
             mirror.replies_seen, mirror.records_sent, mirror.refused_full);
    if (mirror.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
sv/rtk_pkg.sv
sv/rtk_cell.sv
sv/record_table_key_search.sv
verif/record_table_key_search_test.sv
